>>> hw/rtl/ips_pkg.sv
// Shared types, codes and helpers for the irrigation pump sequencer.
// No dependencies; every other file refers to it by scoped names.
package ips_pkg;

	localparam int TIME_W = 32;
	localparam int CMP_W = (TIME_W > 32) ? TIME_W : 32;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_ON = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_OFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_HOLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 3'd6;

	// register reset values
	localparam logic [9:0] RST_DRY_ON = 10'd350;
	localparam logic [9:0] RST_WET_OFF = 10'd550;
	localparam logic [3:0] RST_CONFIRM = 4'd2;
	localparam logic [31:0] RST_MIN_ON = 32'd5000;
	localparam logic [31:0] RST_MIN_OFF = 32'd10000;
	localparam logic [31:0] RST_INV_HOLD = 32'd8000;
	localparam logic [2:0] RST_RETRY_LIM = 3'd3;

	// pump request codes
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_ON = 2'd1;
	localparam logic [1:0] REQ_OFF = 2'd2;

	// decision codes
	localparam logic [3:0] DEC_NONE = 4'd0;
	localparam logic [3:0] DEC_INV_HOLD = 4'd1;
	localparam logic [3:0] DEC_INV_OFF = 4'd2;
	localparam logic [3:0] DEC_PAUSE = 4'd3;
	localparam logic [3:0] DEC_LOCKED = 4'd4;
	localparam logic [3:0] DEC_WET_RESET = 4'd5;
	localparam logic [3:0] DEC_DRY_ON = 4'd6;
	localparam logic [3:0] DEC_MIN_OFF_HOLD = 4'd7;
	localparam logic [3:0] DEC_EXT_OFF = 4'd8;
	localparam logic [3:0] DEC_WET_OFF = 4'd9;
	localparam logic [3:0] DEC_MIN_ON_HOLD = 4'd10;
	localparam logic [3:0] DEC_COOLDOWN = 4'd11;
	localparam logic [3:0] DEC_RESET = 4'd12;

	localparam logic [3:0] CONFIRM_MAX = 4'd15;
	localparam logic [2:0] RETRY_MAX = 3'd7;

	typedef struct packed {
		logic [9:0] dry_on_threshold;
		logic [9:0] wet_off_threshold;
		logic [3:0] confirm_count;
		logic [31:0] min_on_time;
		logic [31:0] min_off_time;
		logic [31:0] invalid_hold_time;
		logic [2:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic [31:0] now_ms;
		logic soil_valid;
		logic [9:0] soil_level;
		logic pump_running;
		logic safety_timeout;
		logic command_accepted;
	} item_t;

	typedef struct packed {
		logic [1:0] pump_request;
		logic clear_safety_flag;
		logic clear_safety_count;
		logic [1:0] machine_state;
		logic [2:0] retries_used;
		logic [3:0] decision;
	} result_t;

	// wrapping difference read as signed, then compared to the duration
	function automatic logic elapsed(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] since, input logic [31:0] dur);
		logic [TIME_W-1:0] d;
		d = now - since;
		return (d[TIME_W-1] == 1'b0) && (CMP_W'(d) >= CMP_W'(dur));
	endfunction

endpackage

>>> hw/rtl/ips_cfg_regs.sv
// Configuration register file of the pump sequencer.
// Depends on ips_pkg for the register indexes, reset values and cfg_t.
module ips_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ips_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [31:0] wr_data,
	output ips_pkg::cfg_t cfg
);

	ips_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_on_threshold <= ips_pkg::RST_DRY_ON;
			cfg_q.wet_off_threshold <= ips_pkg::RST_WET_OFF;
			cfg_q.confirm_count <= ips_pkg::RST_CONFIRM;
			cfg_q.min_on_time <= ips_pkg::RST_MIN_ON;
			cfg_q.min_off_time <= ips_pkg::RST_MIN_OFF;
			cfg_q.invalid_hold_time <= ips_pkg::RST_INV_HOLD;
			cfg_q.retry_limit <= ips_pkg::RST_RETRY_LIM;
		end else if (wr_en) begin
			case (wr_index)
				ips_pkg::CFG_DRY_ON: cfg_q.dry_on_threshold <= wr_data[9:0];
				ips_pkg::CFG_WET_OFF: cfg_q.wet_off_threshold <= wr_data[9:0];
				ips_pkg::CFG_CONFIRM: cfg_q.confirm_count <= wr_data[3:0];
				ips_pkg::CFG_MIN_ON: cfg_q.min_on_time <= wr_data;
				ips_pkg::CFG_MIN_OFF: cfg_q.min_off_time <= wr_data;
				ips_pkg::CFG_INV_HOLD: cfg_q.invalid_hold_time <= wr_data;
				ips_pkg::CFG_RETRY_LIM: cfg_q.retry_limit <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/ips_fsm.sv
// Pump state machine: phase, confirm counters, time stamps and retry count,
// with the next-state and result logic for one word. Depends on ips_pkg.
module ips_fsm (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input ips_pkg::item_t item,
	input ips_pkg::cfg_t cfg,
	output ips_pkg::result_t result
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN = 2'd1,
		PH_PAUSE = 2'd2,
		PH_LOCK = 2'd3
	} phase_t;

	phase_t phase_q, phase_d;
	logic [3:0] on_cnt_q, on_cnt_d, off_cnt_q, off_cnt_d;
	logic [3:0] on_bump, off_bump;
	logic [2:0] tally_q, tally_d, tally_inc;
	logic [ips_pkg::TIME_W-1:0] on_stamp_q, on_stamp_d;
	logic [ips_pkg::TIME_W-1:0] off_stamp_q, off_stamp_d;
	logic [ips_pkg::TIME_W-1:0] inv_stamp_q, inv_stamp_d, inv_since;
	logic [ips_pkg::TIME_W-1:0] now;
	logic [1:0] req;
	logic clr_flag, clr_count;
	logic [3:0] dec;
	logic is_dry, is_wet, off_rested, on_served, hold_over;

	assign now = ips_pkg::TIME_W'(item.now_ms);
	assign is_dry = item.soil_level < cfg.dry_on_threshold;
	assign is_wet = item.soil_level > cfg.wet_off_threshold;
	assign on_bump = (on_cnt_q < ips_pkg::CONFIRM_MAX) ? on_cnt_q + 4'd1 : ips_pkg::CONFIRM_MAX;
	assign off_bump = (off_cnt_q < ips_pkg::CONFIRM_MAX) ? off_cnt_q + 4'd1 :
		ips_pkg::CONFIRM_MAX;
	assign tally_inc = (tally_q < ips_pkg::RETRY_MAX) ? tally_q + 3'd1 : ips_pkg::RETRY_MAX;
	assign inv_since = (inv_stamp_q == '0) ? now : inv_stamp_q;
	assign hold_over = ips_pkg::elapsed(now, inv_since, cfg.invalid_hold_time);
	assign off_rested = (off_stamp_q == '0) ||
		ips_pkg::elapsed(now, off_stamp_q, cfg.min_off_time);
	assign on_served = (on_stamp_q == '0) ||
		ips_pkg::elapsed(now, on_stamp_q, cfg.min_on_time);

	always_comb begin
		phase_d = phase_q;
		on_cnt_d = on_cnt_q;
		off_cnt_d = off_cnt_q;
		tally_d = tally_q;
		on_stamp_d = on_stamp_q;
		off_stamp_d = off_stamp_q;
		inv_stamp_d = inv_stamp_q;
		req = ips_pkg::REQ_NONE;
		clr_flag = 1'b0;
		clr_count = 1'b0;
		dec = ips_pkg::DEC_NONE;

		if (item.kind) begin
			phase_d = PH_IDLE;
			on_cnt_d = '0;
			off_cnt_d = '0;
			tally_d = '0;
			on_stamp_d = '0;
			off_stamp_d = '0;
			inv_stamp_d = '0;
			clr_flag = 1'b1;
			clr_count = 1'b1;
			dec = ips_pkg::DEC_RESET;
		end else if (!item.soil_valid) begin
			on_cnt_d = '0;
			off_cnt_d = '0;
			inv_stamp_d = inv_since;
			if (!hold_over) begin
				dec = ips_pkg::DEC_INV_HOLD;
			end else begin
				req = ips_pkg::REQ_OFF;
				dec = ips_pkg::DEC_INV_OFF;
				if (item.command_accepted) begin
					off_stamp_d = now;
					if (phase_q == PH_RUN)
						phase_d = PH_IDLE;
				end
			end
		end else begin
			inv_stamp_d = '0;
			if (item.safety_timeout) begin
				clr_flag = 1'b1;
				off_stamp_d = now;
				tally_d = tally_inc;
				on_cnt_d = '0;
				off_cnt_d = '0;
				if (tally_inc >= cfg.retry_limit) begin
					phase_d = PH_LOCK;
					dec = ips_pkg::DEC_LOCKED;
				end else begin
					phase_d = PH_PAUSE;
					dec = ips_pkg::DEC_PAUSE;
				end
			end else if (is_wet && (phase_q == PH_LOCK || phase_q == PH_PAUSE)) begin
				phase_d = PH_IDLE;
				tally_d = '0;
				on_cnt_d = '0;
				off_cnt_d = '0;
				dec = ips_pkg::DEC_WET_RESET;
			end else begin
				case (phase_q)
					PH_LOCK: begin
						on_cnt_d = '0;
					end
					PH_PAUSE: begin
						on_cnt_d = '0;
						if (is_dry && off_rested) begin
							phase_d = PH_IDLE;
							dec = ips_pkg::DEC_COOLDOWN;
						end
					end
					PH_IDLE: begin
						off_cnt_d = '0;
						if (is_dry) begin
							on_cnt_d = on_bump;
							if (on_bump >= cfg.confirm_count) begin
								on_cnt_d = '0;
								if (off_rested) begin
									req = ips_pkg::REQ_ON;
									dec = ips_pkg::DEC_DRY_ON;
									if (item.command_accepted) begin
										on_stamp_d = now;
										phase_d = PH_RUN;
									end
								end else begin
									dec = ips_pkg::DEC_MIN_OFF_HOLD;
								end
							end
						end else begin
							on_cnt_d = '0;
						end
					end
					default: begin
						// running
						on_cnt_d = '0;
						if (!item.pump_running) begin
							phase_d = PH_IDLE;
							off_stamp_d = now;
							dec = ips_pkg::DEC_EXT_OFF;
						end else if (is_wet) begin
							off_cnt_d = off_bump;
							if (off_bump >= cfg.confirm_count) begin
								off_cnt_d = '0;
								if (on_served) begin
									req = ips_pkg::REQ_OFF;
									dec = ips_pkg::DEC_WET_OFF;
									if (item.command_accepted) begin
										off_stamp_d = now;
										phase_d = PH_IDLE;
										tally_d = '0;
									end
								end else begin
									dec = ips_pkg::DEC_MIN_ON_HOLD;
								end
							end
						end else begin
							off_cnt_d = '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			on_cnt_q <= '0;
			off_cnt_q <= '0;
			tally_q <= '0;
			on_stamp_q <= '0;
			off_stamp_q <= '0;
			inv_stamp_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			on_cnt_q <= on_cnt_d;
			off_cnt_q <= off_cnt_d;
			tally_q <= tally_d;
			on_stamp_q <= on_stamp_d;
			off_stamp_q <= off_stamp_d;
			inv_stamp_q <= inv_stamp_d;
		end
	end

	assign result.pump_request = req;
	assign result.clear_safety_flag = clr_flag;
	assign result.clear_safety_count = clr_count;
	assign result.machine_state = phase_d;
	assign result.retries_used = tally_d;
	assign result.decision = dec;

endmodule

>>> hw/rtl/irrigation_pump_sequencer.sv
// Top level of the irrigation pump sequencer: input register, result register
// and handshakes. Depends on ips_pkg, ips_cfg_regs and ips_fsm.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | kind now_ms soil_valid soil_level pump_running
//            |                      | safety_timeout command_accepted
//   out      | out_valid / out_stall| pump_request clear_safety_flag clear_safety_count
//            |                      | machine_state retries_used decision
//   cfg      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One word per cycle sustained while out_stall is low; a taken word waits in the
// input register until it fires into the result register, then leaves from there.
// The pump state is registered in the same cycle as the result. arst_n clears state
// and config to reset values. A stalled result holds in the output register while
// one more word waits in the input register; in_stall rises only when both are full.
module irrigation_pump_sequencer (
	input logic clk,
	input logic arst_n,

	input logic in_valid,
	output logic in_stall,
	input logic kind,
	input logic [31:0] now_ms,
	input logic soil_valid,
	input logic [9:0] soil_level,
	input logic pump_running,
	input logic safety_timeout,
	input logic command_accepted,

	output logic out_valid,
	input logic out_stall,
	output logic [1:0] pump_request,
	output logic clear_safety_flag,
	output logic clear_safety_count,
	output logic [1:0] machine_state,
	output logic [2:0] retries_used,
	output logic [3:0] decision,

	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ips_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	ips_pkg::cfg_t cfg;
	ips_pkg::item_t item_s1;
	ips_pkg::result_t result, result_s2;
	logic valid_s1_q, valid_s2_q;
	logic fire, take;

	assign cfg_ready = 1'b1;

	ips_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	// advance the held word whenever the result register is free or draining
	assign fire = valid_s1_q && (!valid_s2_q || !out_stall);
	assign in_stall = valid_s1_q && !fire;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (take) begin
			valid_s1_q <= 1'b1;
		end else if (fire) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind <= kind;
			item_s1.now_ms <= now_ms;
			item_s1.soil_valid <= soil_valid;
			item_s1.soil_level <= soil_level;
			item_s1.pump_running <= pump_running;
			item_s1.safety_timeout <= safety_timeout;
			item_s1.command_accepted <= command_accepted;
		end
	end

	ips_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
		end else if (fire) begin
			valid_s2_q <= 1'b1;
		end else if (!out_stall) begin
			valid_s2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2_q;
	assign pump_request = result_s2.pump_request;
	assign clear_safety_flag = result_s2.clear_safety_flag;
	assign clear_safety_count = result_s2.clear_safety_count;
	assign machine_state = result_s2.machine_state;
	assign retries_used = result_s2.retries_used;
	assign decision = result_s2.decision;

endmodule
